@@ hdl/bpc_pkg.sv @@
package bpc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int DIV_STAGES  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_P1    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_P2    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_P3    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_P4    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_P5    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_P6    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_P7    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_P8_P9 = 3'd7;

    typedef struct packed {
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } coef_t;

    // Numerator and divisor of the main division, as handed from front to back.
    typedef struct packed {
        logic [63:0] num;
        logic [30:0] den;
        logic        zero;
    } div_item_t;

    typedef struct packed {
        logic [31:0] pressure;
        logic        zero;
    } result_t;

    // Partial products for the low 64 bits of a 64 by 64 product.
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } pp_t;

    function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
        pp_t         r;
        logic [63:0] t_lh;
        logic [63:0] t_hl;
        r.ll = a[31:0] * b[31:0];
        t_lh = a[31:0] * b[63:32];
        t_hl = a[63:32] * b[31:0];
        r.lh = t_lh[31:0];
        r.hl = t_hl[31:0];
        return r;
    endfunction

    function automatic logic [63:0] mul_sum(input pp_t p);
        logic [31:0] mid;
        mid = p.lh + p.hl;
        return p.ll + {mid, 32'd0};
    endfunction

endpackage

@@ hdl/bpc_fifo.sv @@
module bpc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hdl/bpc_front.sv @@
module bpc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [23:0]       raw_pressure,
    input  logic signed [19:0] fine_temperature,
    input  bpc_pkg::coef_t    coef,
    output logic              out_valid,
    input  logic              out_ready,
    output bpc_pkg::div_item_t out_item
);
    import bpc_pkg::*;

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg;
    logic              en;

    logic signed [21:0] v1_reg;
    logic [19:0]        adc_reg;
    logic signed [43:0] sq_reg;
    logic signed [37:0] m5_reg, m2_reg, m5_reg2, m2_reg2;
    logic signed [21:0] pn_reg, pn_reg2, pn_reg3;
    logic signed [63:0] t6_reg, t3_reg;
    logic signed [63:0] v2_reg, var1_reg;
    logic [63:0]        d_reg, num0_reg;
    logic [63:0]        num_reg;
    logic [30:0]        den_reg;
    logic               zero_reg;

    logic signed [21:0] tf_ext;
    logic signed [63:0] m5_ext, m2_ext, p4_ext, pn_ext, a_ext;
    logic signed [65:0] d_prod;
    logic [63:0]        num_prod;

    assign en        = !(vld_reg[STAGES-1] && !out_ready);
    assign in_ready  = en;
    assign out_valid = vld_reg[STAGES-1];
    assign out_item  = '{num: num_reg, den: den_reg, zero: zero_reg};

    always_comb
    begin
        tf_ext   = fine_temperature;
        m5_ext   = m5_reg2;
        m2_ext   = m2_reg2;
        p4_ext   = coef.p4;
        pn_ext   = pn_reg3;
        a_ext    = 64'sh0000_8000_0000_0000 + var1_reg;
        // The offset term stays below 2^49, so 50 bits carry it into the wrapping product.
        d_prod   = $signed(a_ext[49:0]) * $signed({1'b0, coef.p1});
        num_prod = num0_reg * 64'd3125;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg   <= tf_ext - 22'sd128000;
            adc_reg  <= raw_pressure[23:4];

            sq_reg   <= v1_reg * v1_reg;
            m5_reg   <= v1_reg * coef.p5;
            m2_reg   <= v1_reg * coef.p2;
            pn_reg   <= 22'sd1048576 - $signed({2'b00, adc_reg});

            t6_reg   <= sq_reg * coef.p6;
            t3_reg   <= sq_reg * coef.p3;
            m5_reg2  <= m5_reg;
            m2_reg2  <= m2_reg;
            pn_reg2  <= pn_reg;

            v2_reg   <= t6_reg + (m5_ext <<< 17) + (p4_ext <<< 35);
            var1_reg <= (t3_reg >>> 8) + (m2_ext <<< 12);
            pn_reg3  <= pn_reg2;

            d_reg    <= d_prod[63:0];
            num0_reg <= (pn_ext <<< 31) - v2_reg;

            den_reg  <= d_reg[63:33];
            zero_reg <= (d_reg[63:33] == '0);
            num_reg  <= num_prod;
        end
    end

endmodule

@@ hdl/bpc_back.sv @@
module bpc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bpc_pkg::div_item_t in_item,
    input  bpc_pkg::coef_t     coef,
    output logic               out_valid,
    input  logic               out_ready,
    output bpc_pkg::result_t   out_result
);
    import bpc_pkg::*;

    localparam int N = DIV_STAGES;

    logic        en;

    // Restoring divider, one quotient bit per stage.
    logic        dv_reg   [0:N];
    logic [63:0] dq_reg   [0:N];
    logic [30:0] rem_reg  [0:N];
    logic [30:0] ub_reg   [0:N];
    logic        neg_reg  [0:N];
    logic        zero_reg [0:N];

    logic [31:0] trial    [0:N-1];
    logic        qbit     [0:N-1];

    logic [6:0]         pv_reg;
    logic [6:0]         pz_reg;
    logic signed [63:0] q1_reg, q2_reg, q3_reg, q4_reg, q5_reg, q6_reg;
    pp_t                ppsq_reg, pp8_reg, pp9_reg;
    logic signed [63:0] sq_reg, m8_reg, v2b_reg, v2b_reg2, v1b_reg;
    logic signed [63:0] t_reg;

    logic               na, nb;
    logic signed [63:0] s13, p8_ext, p9_ext, p7_ext, v1b_sum, rnd;

    assign en        = !(pv_reg[6] && !out_ready);
    assign in_ready  = en;
    assign out_valid = pv_reg[6];

    always_comb
    begin
        na      = in_item.num[63];
        nb      = in_item.den[30];
        s13     = q2_reg >>> 13;
        p8_ext  = coef.p8;
        p9_ext  = coef.p9;
        p7_ext  = coef.p7;
        v1b_sum = mul_sum(pp9_reg);
        // An arithmetic shift by 8 rounds down, so negative values are biased first to round toward zero.
        rnd     = (t_reg + (t_reg[63] ? 64'sd255 : 64'sd0)) >>> 8;
        out_result.pressure = pz_reg[6] ? 32'd0 : rnd[31:0];
        out_result.zero     = pz_reg[6];
        for (int k = 0; k < N; k++)
        begin
            trial[k] = {rem_reg[k], dq_reg[k][63]};
            qbit[k]  = (trial[k] >= {1'b0, ub_reg[k]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
            pv_reg <= '0;
        end
        else if (en)
        begin
            dv_reg[0] <= in_valid;
            for (int k = 0; k < N; k++)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
            pv_reg <= {pv_reg[5:0], dv_reg[N]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dq_reg[0]   <= na ? (64'd0 - in_item.num) : in_item.num;
            ub_reg[0]   <= nb ? (31'd0 - in_item.den) : in_item.den;
            rem_reg[0]  <= '0;
            neg_reg[0]  <= na ^ nb;
            zero_reg[0] <= in_item.zero;
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k+1]  <= qbit[k] ? 31'(trial[k] - {1'b0, ub_reg[k]}) : trial[k][30:0];
                dq_reg[k+1]   <= {dq_reg[k][62:0], qbit[k]};
                ub_reg[k+1]   <= ub_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end

            pz_reg   <= {pz_reg[5:0], zero_reg[N]};

            q1_reg   <= neg_reg[N] ? $signed(64'd0 - dq_reg[N]) : $signed(dq_reg[N]);

            q2_reg   <= q1_reg;

            ppsq_reg <= mul_pp(s13, s13);
            pp8_reg  <= mul_pp(q2_reg, p8_ext);
            q3_reg   <= q2_reg;

            sq_reg   <= mul_sum(ppsq_reg);
            m8_reg   <= mul_sum(pp8_reg);
            q4_reg   <= q3_reg;

            pp9_reg  <= mul_pp(sq_reg, p9_ext);
            v2b_reg  <= m8_reg >>> 19;
            q5_reg   <= q4_reg;

            v1b_reg  <= v1b_sum >>> 25;
            v2b_reg2 <= v2b_reg;
            q6_reg   <= q5_reg;

            t_reg    <= ((q6_reg + v1b_reg + v2b_reg2) >>> 8) + (p7_ext <<< 4);
        end
    end

endmodule

@@ hdl/barometric_pressure_compensation.sv @@
// Pressure compensation engine: one raw 24-bit reading and a fine temperature go in, and the
// pressure in pascals comes out, using the nine calibration coefficients from the register
// port. It accepts one request per clock while the front end is not held by a full middle
// queue; a request passes 80 register stages (6 in the front end, one in each queue, 65 in
// the one-bit-per-stage divider and 7 after it) before its result is visible. A divisor of
// zero gives 0 with divisor_zero set. Coefficients should be written only while no requests
// are in flight.
module barometric_pressure_compensation #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [23:0]                         raw_pressure,
    input  logic signed [19:0]                  fine_temperature,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [31:0]                  pressure_pa,
    output logic                                divisor_zero,
    input  logic                                cfg_we,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bpc_pkg::*;

    localparam int DIV_W = $bits(div_item_t);
    localparam int RES_W = $bits(result_t);

    coef_t      coef_reg;
    logic       fr_valid, mid_full, mid_empty, bk_ready, bk_valid, out_full;
    div_item_t  fr_item, mid_item;
    logic [DIV_W-1:0] mid_raw;
    result_t    bk_result, out_result;
    logic [RES_W-1:0] out_raw;
    logic       in_ready;

    assign full = !in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_P1:    coef_reg.p1 <= cfg_data[15:0];
                REG_P2:    coef_reg.p2 <= cfg_data[15:0];
                REG_P3:    coef_reg.p3 <= cfg_data[15:0];
                REG_P4:    coef_reg.p4 <= cfg_data[15:0];
                REG_P5:    coef_reg.p5 <= cfg_data[15:0];
                REG_P6:    coef_reg.p6 <= cfg_data[15:0];
                REG_P7:    coef_reg.p7 <= cfg_data[15:0];
                REG_P8_P9:
                begin
                    coef_reg.p8 <= cfg_data[15:0];
                    coef_reg.p9 <= cfg_data[31:16];
                end
                default:   coef_reg <= coef_reg;
            endcase
        end
    end

    bpc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (push),
        .in_ready         (in_ready),
        .raw_pressure     (raw_pressure),
        .fine_temperature (fine_temperature),
        .coef             (coef_reg),
        .out_valid        (fr_valid),
        .out_ready        (!mid_full),
        .out_item         (fr_item)
    );

    bpc_fifo #(
        .WIDTH (DIV_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fr_valid),
        .wr_data (fr_item),
        .rd_en   (bk_ready),
        .rd_data (mid_raw),
        .full    (mid_full),
        .empty   (mid_empty)
    );

    assign mid_item = div_item_t'(mid_raw);

    bpc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (!mid_empty),
        .in_ready   (bk_ready),
        .in_item    (mid_item),
        .coef       (coef_reg),
        .out_valid  (bk_valid),
        .out_ready  (!out_full),
        .out_result (bk_result)
    );

    bpc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (bk_valid),
        .wr_data (bk_result),
        .rd_en   (pop),
        .rd_data (out_raw),
        .full    (out_full),
        .empty   (empty)
    );

    assign out_result   = result_t'(out_raw);
    assign pressure_pa  = $signed(out_result.pressure);
    assign divisor_zero = out_result.zero;

endmodule
